[rtl/swm_pkg.sv]
// Shared widths and defaults for the sliding window minimum unit.
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 11;
  localparam int MAX_WINDOW_DEF = 1024;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

endpackage : swm_pkg

[rtl/sliding_window_minimum_unit.sv]
// Sliding window minimum: a monotonic deque held in one RAM.
// Per sample: a head check, a further step when the front leaves the window with entries
//   behind it, one back step per entry popped from the deque tail, and the push.
// The result beat goes to a registered output and waits while that register stays full;
//   the input waits meanwhile, so a new sample is taken only once the last is through.
// Reset: synchronous, active low; clears control, pointers and counts; the RAM is not cleared.
module sliding_window_minimum_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input stream. in_tdata fields from bit 0: sample[31:0].
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,
  // Result stream. out_tdata fields from bit 0: window_min[31:0].
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,
  // Configuration write channel carrying window_size.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  // Pointer, window and sequence widths. The sequence tag needs one bit more
  // than the pointer so that an age of exactly MAX_WINDOW is still visible.
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int SW = AW + 1;
  localparam int CW = (CFG_W > WW) ? CFG_W : WW;
  localparam int EW = SW + SAMPLE_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_NEWHEAD,
    S_BACK,
    S_WAIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [WW-1:0]       win_r, win_nxt;
  logic [WW-1:0]       fill_r, fill_nxt;
  logic [SW-1:0]       seq_r, seq_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [WW-1:0]       count_r, count_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SW-1:0]       cur_seq_r, cur_seq_nxt;
  logic                emit_r, emit_nxt;
  logic [SAMPLE_W-1:0] head_val_r, head_val_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  logic [SAMPLE_W-1:0] rd_val;
  logic [SW-1:0]       rd_seq;
  logic [SW-1:0]       rd_age;
  logic                head_expired;
  logic                slot_free;
  logic [CW-1:0]       cfg_ext;
  logic [WW-1:0]       eff_win;
  logic [WW-1:0]       fill_inc;
  logic [SAMPLE_W-1:0] push_min;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_ADDR : p - AW'(1);
  endfunction

  // Each deque entry holds the sample and the sequence tag of its arrival.
  swm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WINDOW)
  ) u_deque (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {cur_seq_r, sample_r};
  assign rd_val    = ram_rdata[SAMPLE_W-1:0];
  assign rd_seq    = ram_rdata[EW-1:SAMPLE_W];

  // The front entry leaves the window once its age reaches the window size.
  // Only one entry can reach that age per sample.
  assign rd_age       = cur_seq_r - rd_seq;
  assign head_expired = (rd_age >= SW'(win_r));

  // A zero window acts as one sample; a window beyond the store saturates.
  assign cfg_ext = CW'(cfg_data);
  always_comb begin
    priority if (cfg_ext == '0) begin
      eff_win = WW'(1);
    end else if (cfg_ext > CW'(MAX_WINDOW)) begin
      eff_win = WW'(MAX_WINDOW);
    end else begin
      eff_win = WW'(cfg_ext);
    end
  end

  assign fill_inc  = (fill_r < win_r) ? fill_r + WW'(1) : fill_r;
  assign slot_free = !out_valid_r || out_tready;
  assign push_min  = (count_r == '0) ? sample_r : head_val_r;

  assign cfg_ready  = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Per sample: read the front (drop it if it aged out), walk back from the
  // tail popping every entry not smaller than the new sample, then push the
  // sample. The front value is then the window minimum. The write of a push
  // always lands before the next sample's first read, so no forwarding path
  // is needed.
  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    seq_nxt       = seq_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    sample_nxt    = sample_r;
    cur_seq_nxt   = cur_seq_r;
    emit_nxt      = emit_r;
    head_val_nxt  = head_val_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = head_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = head_r;
        if (cfg_valid) begin
          // A new window size restarts the fill and empties the deque.
          win_nxt   = eff_win;
          fill_nxt  = '0;
          count_nxt = '0;
          head_nxt  = tail_r;
        end else if (in_tvalid) begin
          sample_nxt  = in_tdata;
          cur_seq_nxt = seq_r;
          seq_nxt     = seq_r + SW'(1);
          fill_nxt    = fill_inc;
          emit_nxt    = (fill_inc == win_r);
          state_nxt   = S_HEAD;
        end
      end
      S_HEAD: begin
        if ((count_r != '0) && head_expired) begin
          head_nxt  = ptr_next(head_r);
          count_nxt = count_r - WW'(1);
          if (count_r > WW'(1)) begin
            ram_raddr = ptr_next(head_r);
            state_nxt = S_NEWHEAD;
          end else begin
            state_nxt = S_BACK;
          end
        end else begin
          head_val_nxt = rd_val;
          ram_raddr    = ptr_prev(tail_r);
          state_nxt    = S_BACK;
        end
      end
      S_NEWHEAD: begin
        head_val_nxt = rd_val;
        ram_raddr    = ptr_prev(tail_r);
        state_nxt    = S_BACK;
      end
      S_BACK: begin
        if ((count_r != '0) && (rd_val >= sample_r)) begin
          tail_nxt  = ptr_prev(tail_r);
          count_nxt = count_r - WW'(1);
          ram_raddr = ptr_prev(ptr_prev(tail_r));
        end else begin
          ram_we    = 1'b1;
          tail_nxt  = ptr_next(tail_r);
          count_nxt = count_r + WW'(1);
          if (!emit_r) begin
            state_nxt = S_IDLE;
          end else if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = push_min;
            state_nxt     = S_IDLE;
          end else begin
            min_nxt   = push_min;
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = min_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WW'(WINDOW_RESET);
      fill_r      <= '0;
      seq_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      seq_r       <= seq_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    cur_seq_r  <= cur_seq_nxt;
    head_val_r <= head_val_nxt;
    min_r      <= min_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The deque never holds more entries than the window.
  a_count_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= win_r)
    else $error("deque holds more entries than the window");

  // The fill count saturates at the window size.
  a_fill_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count passed the window size");

  // An empty deque has its head and tail pointers together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty deque with split pointers");

  // A result waits in its own state only while the output register is busy.
  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> out_valid_r)
    else $error("result held back with a free output register");
`endif

endmodule : sliding_window_minimum_unit

[rtl/swm_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : swm_ram

[bench/tb_top.sv]
// Self-checking stimulus and scoreboard for the sliding window minimum unit.
`timescale 1ns / 100ps

module tb_top
  import swm_pkg::*;
();

  // A single sample is at most one pass over a full window of deque pops
  // (plus the head check and the push), so SETTLE_CYCLES always covers an item
  // that is still in flight but yields no beat.
  localparam int unsigned SETTLE_CYCLES = MAX_WINDOW_DEF + 32;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int unsigned HOLD_CYCLES   = 600;
  // Samples in the randomized part.
  localparam int unsigned SAMPLE_TARGET = 1750;
  // Generous ceiling on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_VALUE} row_check_t;
  typedef enum logic [2:0] {
    SHAPE_UNIFORM, SHAPE_RISING, SHAPE_FALLING, SHAPE_NARROW, SHAPE_EXTREME
  } sample_shape_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [SAMPLE_W-1:0] value;   // sample, or window size for a register write
    row_check_t          check;
    logic [SAMPLE_W-1:0] result;  // typed-in minimum, used with CHK_VALUE
  } stim_row_t;

  localparam int unsigned DIRECTED_LEN = 31;

  // Directed sequence. Results are typed in where they are obvious; the last
  // three rows, from the end of the descending run on, go to the predictor.
  localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
    // Window of one after reset: every beat echoes its own sample.
    '{ROW_SAMPLE, 32'h0000_0000, CHK_VALUE, 32'h0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, CHK_VALUE, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 32'h1234_5678, CHK_VALUE, 32'h1234_5678},
    // Window of three: two silent samples while filling, then the front
    // of the window expiring.
    '{ROW_WINDOW, 32'd3,         CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0010, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0020, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0005, CHK_VALUE, 32'h0000_0005},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, CHK_VALUE, 32'h0000_0005},
    '{ROW_SAMPLE, 32'h0000_0007, CHK_VALUE, 32'h0000_0005},
    '{ROW_SAMPLE, 32'h0000_0008, CHK_VALUE, 32'h0000_0007},
    '{ROW_SAMPLE, 32'h0000_0009, CHK_VALUE, 32'h0000_0007},
    '{ROW_SAMPLE, 32'h0000_000A, CHK_VALUE, 32'h0000_0008},
    // A window size of zero behaves as a window of one.
    '{ROW_WINDOW, 32'd0,         CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, CHK_VALUE, 32'h8000_0000},
    '{ROW_SAMPLE, 32'h0000_0001, CHK_VALUE, 32'h0000_0001},
    // The largest register value saturates to the full store; it only fills.
    '{ROW_WINDOW, 32'd2047,      CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0000, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, CHK_NONE,  32'h0},
    // Window of two around the top of the sample range.
    '{ROW_WINDOW, 32'd2,         CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, CHK_VALUE, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 32'h0000_0000, CHK_VALUE, 32'h0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFE, CHK_VALUE, 32'h0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, CHK_VALUE, 32'hFFFF_FFFE},
    // Window of four on a descending run, then a rise and a new low.
    '{ROW_WINDOW, 32'd4,         CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0040, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0030, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0020, CHK_NONE,  32'h0},
    '{ROW_SAMPLE, 32'h0000_0010, CHK_PREDICT, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0050, CHK_PREDICT, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0005, CHK_PREDICT, 32'h0}
  };

  // Clock, reset and block ports. Everything the bench drives starts known.
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata   = '0;   // fields from bit 0: sample[31:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;         // fields from bit 0: window_min[31:0]
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data   = '0;

  // Predictor state: its own copy of the sample ring, fill count, write
  // pointer and window register.
  logic [SAMPLE_W-1:0] sample_ring [MAX_WINDOW_DEF];
  int unsigned         ring_wr_ptr = 0;
  int unsigned         ring_fill   = 0;
  logic [CFG_W-1:0]    window_reg  = WINDOW_RESET;

  // Minima still owed by the block, oldest first.
  logic [SAMPLE_W-1:0] min_expected [$];

  int unsigned   fault_count   = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   samples_sent  = 0;
  int unsigned   burst_left    = 0;
  bit            hold_req      = 1'b0;
  sample_shape_t shape         = SHAPE_UNIFORM;
  int unsigned   shape_left    = 0;
  logic [SAMPLE_W-1:0] ramp    = '0;

  sliding_window_minimum_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A window register of zero acts as one; anything past the store saturates.
  function automatic int unsigned span_of(input logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return int'(w);
  endfunction

  // Enters a sample into the predictor ring and, once the window is full,
  // returns the minimum over the newest span samples.
  function automatic void predict_window_min(input logic [SAMPLE_W-1:0] s,
                                             output bit has_min,
                                             output logic [SAMPLE_W-1:0] m);
    int unsigned span;
    int unsigned p;
    int unsigned i;
    span = span_of(window_reg);
    sample_ring[ring_wr_ptr] = s;
    p = ring_wr_ptr;
    ring_wr_ptr = (ring_wr_ptr + 1) % MAX_WINDOW_DEF;
    if (ring_fill < span) ring_fill++;
    has_min = (ring_fill >= span);
    m = s;
    if (has_min) begin
      for (i = 1; i < span; i++) begin
        p = (p == 0) ? MAX_WINDOW_DEF - 1 : p - 1;
        if (sample_ring[p] < m) m = sample_ring[p];
      end
    end
  endfunction

  // Samples come in runs of one shape: rising and falling runs drive the
  // deque through long pop chains and front expiry, narrow runs make ties.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    logic [SAMPLE_W-1:0] s;
    if (shape_left == 0) begin
      shape      = sample_shape_t'($urandom_range(0, 4));
      shape_left = $urandom_range(1, 64);
      ramp       = $urandom();
    end
    shape_left--;
    case (shape)
      SHAPE_RISING: begin
        ramp = ramp + $urandom_range(0, 4000);
        s    = ramp;
      end
      SHAPE_FALLING: begin
        ramp = ramp - $urandom_range(0, 4000);
        s    = ramp;
      end
      SHAPE_NARROW: s = ramp + $urandom_range(0, 7);
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       s = 32'h0000_0000;
          1:       s = 32'h0000_0001;
          2:       s = 32'hFFFF_FFFE;
          default: s = 32'hFFFF_FFFF;
        endcase
      end
      default: s = $urandom();
    endcase
    return s;
  endfunction

  // Sender pacing: bursts of random length, mostly short, sometimes long,
  // separated by random gaps (sometimes none at all).
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Offers one sample beat and, once it is taken, records what it must yield.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input row_check_t chk,
                             input logic [SAMPLE_W-1:0] typed);
    bit                  has_min;
    logic [SAMPLE_W-1:0] m;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    predict_window_min(s, has_min, m);
    case (chk)
      CHK_PREDICT: if (has_min) min_expected.push_back(m);
      CHK_VALUE:   min_expected.push_back(typed);
      default:     ;
    endcase
    samples_sent++;
    pace_sender();
  endtask

  // Stops offering samples and waits for every owed beat to arrive.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (min_expected.size() != 0) @(posedge clk);
  endtask

  // Window writes happen only with the block idle: all beats delivered, and
  // time left for a trailing sample that yields nothing to finish its pops.
  task automatic write_window(input logic [CFG_W-1:0] w);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    window_reg = w;
    ring_fill  = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: reset, the directed table, then randomized window phases.
  initial begin : stimulus
    int unsigned      row;
    int unsigned      phase;
    int unsigned      count;
    int unsigned      k;
    int unsigned      hold_at;
    int unsigned      pause_at;
    logic [CFG_W-1:0] w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < DIRECTED_LEN; row++) begin
      if (DIRECTED_ROWS[row].kind == ROW_WINDOW) begin
        write_window(DIRECTED_ROWS[row].value[CFG_W-1:0]);
      end else begin
        send_sample(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].check,
                    DIRECTED_ROWS[row].result);
      end
    end

    // Each phase picks a window, fills it and runs 30 to 120 beats past the
    // fill. Phase two uses the largest register value, which saturates to the
    // full store; all other phases keep the window small.
    phase = 0;
    samples_sent = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      if (phase == 2) begin
        w = CFG_W'(2047);
      end else begin
        case ($urandom_range(0, 5))
          0:       w = CFG_W'(0);
          1:       w = CFG_W'(1);
          2:       w = CFG_W'(2);
          3:       w = CFG_W'($urandom_range(3, 16));
          4:       w = CFG_W'($urandom_range(17, 64));
          default: w = CFG_W'($urandom_range(65, 200));
        endcase
      end
      write_window(w);
      count    = span_of(w) + $urandom_range(30, 120);
      // Hold-off right after the fill in the first two phases, so the
      // sender keeps pushing into a block whose results cannot leave.
      hold_at  = (phase < 2) ? span_of(w) : count;
      pause_at = (phase == 1 || $urandom_range(0, 3) == 0) ? count / 2 : count;
      for (k = 0; k < count; k++) begin
        send_sample(next_sample(), CHK_PREDICT, '0);
        if (k == hold_at) hold_req = 1'b1;
        if (k == pause_at) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result sink: ready follows a pattern that changes every stretch (always
  // ready, coin flip, mostly ready, one cycle in a period), and on request it
  // holds off for a long count of its own.
  initial begin : result_sink
    int unsigned stretch;
    int unsigned mode;
    int unsigned period;
    int unsigned tick;
    forever begin
      stretch = $urandom_range(16, 256);
      mode    = $urandom_range(0, 3);
      period  = $urandom_range(2, 6);
      for (tick = 0; tick < stretch; tick++) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 3) != 0);
            default: out_tready <= (tick % period == 0);
          endcase
        end
      end
    end
  end

  // Scoreboard: every result beat must match the oldest owed minimum.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (min_expected.size() == 0) begin
        $error("window_min beat with nothing owed: expected none, actual %h", out_tdata);
        fault_count++;
      end else begin
        if (out_tdata !== min_expected[0]) begin
          $error("window_min mismatch: expected %h, actual %h",
                 min_expected[0], out_tdata);
          fault_count++;
        end
        void'(min_expected.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule : tb_top

[sliding_window_minimum_unit.f]
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/sliding_window_minimum_unit.sv
bench/tb_top.sv
